### rtl/mede_pkg.sv
// ----------------------------------------------------------------------------
// mede_pkg
// Shared codes, types and the filter weight table of the error-diffusion
// engine.
// ----------------------------------------------------------------------------
package mede_pkg;

  localparam int ERR_W    = 16;
  localparam int NUM_TAPS = 12;

  localparam logic MODE_FETCH = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  localparam logic REG_FILTER = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [3:0][ERR_W-1:0]   err_vec_t;
  typedef logic [15:0]             weight_t;

  // Q0.16 weights, tap order: row 0 at +1,+2; row 1 at -2..+2; row 2 at -2..+2
  localparam weight_t WEIGHT_TBL [8][NUM_TAPS] = '{
    '{16'd28672, 16'd0,     16'd0,     16'd12288, 16'd20480, 16'd4096,  16'd0,
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd32768, 16'd0,     16'd0,     16'd16384, 16'd16384, 16'd0,     16'd0,
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd8192,  16'd8192,  16'd0,     16'd8192,  16'd8192,  16'd8192,  16'd0,
      16'd0,     16'd0,     16'd8192,  16'd0,     16'd0},
    '{16'd16384, 16'd8192,  16'd4096,  16'd8192,  16'd16384, 16'd8192,  16'd4096,
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd9557,  16'd6827,  16'd4096,  16'd6827,  16'd9557,  16'd6827,  16'd4096,
      16'd1365,  16'd4096,  16'd6827,  16'd4096,  16'd1365},
    '{16'd16384, 16'd12288, 16'd4096,  16'd8192,  16'd12288, 16'd8192,  16'd4096,
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd10240, 16'd6144,  16'd4096,  16'd8192,  16'd10240, 16'd8192,  16'd4096,
      16'd0,     16'd4096,  16'd6144,  16'd4096,  16'd0},
    '{16'd12483, 16'd6242,  16'd3121,  16'd6242,  16'd12483, 16'd6242,  16'd3121,
      16'd1560,  16'd3121,  16'd6242,  16'd3121,  16'd1560}
  };

  function automatic logic [1:0] tap_row(input logic [3:0] k);
    logic [1:0] r;
    if (k < 4'd2) r = 2'd0;
    else if (k < 4'd7) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  // entry offset 0..4 relative to entry "column", i.e. pixel offset -2..+2
  function automatic logic [2:0] tap_off(input logic [3:0] k);
    logic [3:0] o;
    if (k < 4'd2) o = k + 4'd3;
    else if (k < 4'd7) o = k - 4'd2;
    else o = k - 4'd7;
    return o[2:0];
  endfunction

  function automatic weight_t tap_weight(input logic [2:0] f, input logic [3:0] k);
    weight_t w;
    w = '0;
    if (k < 4'(NUM_TAPS)) w = WEIGHT_TBL[f][k];
    return w;
  endfunction

endpackage

### rtl/mede_ram.sv
// ----------------------------------------------------------------------------
// mede_ram
// Error row storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mede_ram #(
  parameter int DEPTH = 3084,
  parameter int AW    = 12,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mede_mac.sv
// ----------------------------------------------------------------------------
// mede_mac
// Weighted error products (registered) and saturating accumulate into the
// entry read back from the row memory.
// ----------------------------------------------------------------------------
module mede_mac #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        a_valid,
  input  mede_pkg::err_vec_t          err,
  input  mede_pkg::weight_t           weight,
  input  logic [4*CHANNEL_BITS-1:0]   rdata,
  output logic [4*CHANNEL_BITS-1:0]   wdata
);

  import mede_pkg::*;

  localparam int SW = ((CHANNEL_BITS > 18) ? CHANNEL_BITS : 18) + 1;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (CHANNEL_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic signed [32:0] prod_r [4];

  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c] <= $signed(err[c]) * $signed({1'b0, weight});
      end
    end
  end

  always_comb begin
    logic signed [33:0]             q;
    logic signed [17:0]             delta;
    logic signed [CHANNEL_BITS-1:0] ent;
    logic signed [SW-1:0]           sum;
    wdata = '0;
    for (int c = 0; c < 4; c++) begin
      // round half up: floor((p + 2^15) / 2^16)
      q     = 34'(prod_r[c]) + 34'sd32768;
      delta = q[33:16];
      ent   = rdata[c*CHANNEL_BITS +: CHANNEL_BITS];
      sum   = SW'(ent) + SW'(delta);
      if (sum > HI) sum = HI;
      else if (sum < LO) sum = LO;
      wdata[c*CHANNEL_BITS +: CHANNEL_BITS] = sum[CHANNEL_BITS-1:0];
    end
  end

endmodule

### rtl/matrix_error_diffusion_engine_unit.sv
// ----------------------------------------------------------------------------
// matrix_error_diffusion_engine_unit
// Four-channel error-diffusion store with eight selectable filters.
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  mode, column, four errors
//   out_     out  out_valid/out_stall four accumulated offsets
//   cfg_     in   cfg_we             filter select, image width
//
// Fetch: reads the entry, then registers it for output; at column 0 the new
// row is cleared first. Store: 12 tap read-modify-writes through the one RAM
// port pair, plus issue and drain; a store outside the line is dropped.
// After reset a clearing pass over all ERROR_ROWS*(MAX_WIDTH+4) entries runs
// while in_stall is high. The output register lets the next word in while a
// result waits on out_stall.
// ----------------------------------------------------------------------------
module matrix_error_diffusion_engine_unit #(
  parameter int MAX_WIDTH    = 1024,
  parameter int ERROR_ROWS   = 3,
  parameter int CHANNEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [9:0]         in_column,
  input  mede_pkg::err_t     in_err_red,
  input  mede_pkg::err_t     in_err_green,
  input  mede_pkg::err_t     in_err_blue,
  input  mede_pkg::err_t     in_err_alpha,
  output logic               out_valid,
  input  logic               out_stall,
  output mede_pkg::err_t     out_offset_red,
  output mede_pkg::err_t     out_offset_green,
  output mede_pkg::err_t     out_offset_blue,
  output mede_pkg::err_t     out_offset_alpha
);

  import mede_pkg::*;

  localparam int ROW_LEN = MAX_WIDTH + 4;
  localparam int DEPTH   = ERROR_ROWS * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(ROW_LEN);
  localparam int XW      = (CW > 11) ? CW : 11;
  localparam int DW      = 4 * CHANNEL_BITS;
  localparam int OW      = (CHANNEL_BITS > 16) ? CHANNEL_BITS : 16;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLR, S_FRD, S_FOUT, S_STO, S_DRN
  } state_t;

  state_t         state_r;
  logic [1:0]     top_r;
  logic [1:0]     clr_row_r;
  logic [AW-1:0]  cnt_r;
  logic [9:0]     col_r;
  logic           inside_r;
  logic [3:0]     tap_r;
  err_vec_t       err_r;
  logic [2:0]     filter_r;
  logic [10:0]    width_r;
  logic           b_we_r;
  logic [AW-1:0]  b_waddr_r;
  logic           out_valid_r;
  err_t           out_r [4];

  logic           in_acc;
  logic           in_line;
  logic [1:0]     tap_iy;
  logic [2:0]     tap_ix;
  logic [2:0]     row_sum;
  logic [1:0]     tap_phys;
  weight_t        tap_w;
  logic           tap_valid;
  logic [AW-1:0]  tap_addr;
  logic [AW-1:0]  fetch_addr;
  logic [XW-1:0]  tap_idx;
  logic [XW-1:0]  fetch_idx;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [DW-1:0]  ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [DW-1:0]  ram_rdata;
  logic [DW-1:0]  mac_wdata;

  function automatic logic [AW-1:0] row_base(input logic [1:0] r);
    return AW'(r) * AW'(ROW_LEN);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // col < max(width,1) and col < MAX_WIDTH
  assign in_line  = ((11'(in_column) < width_r) || (in_column == 10'd0)) &&
                    (32'(in_column) < MAX_WIDTH);

  assign tap_iy   = tap_row(tap_r);
  assign tap_ix   = tap_off(tap_r);
  assign tap_w    = tap_weight(filter_r, tap_r);
  assign row_sum  = {1'b0, top_r} + {1'b0, tap_iy};
  assign tap_phys = (32'(row_sum) >= ERROR_ROWS) ? 2'(32'(row_sum) - ERROR_ROWS)
                                                 : row_sum[1:0];
  assign tap_valid = (tap_w != '0) && (32'(tap_iy) < ERROR_ROWS);
  assign tap_idx   = XW'(col_r) + XW'(tap_ix);
  assign tap_addr  = row_base(tap_phys) + AW'(tap_idx);
  assign fetch_idx = XW'(col_r) + XW'(2);
  assign fetch_addr = row_base(top_r) + AW'(fetch_idx);

  always_comb begin
    ram_we    = b_we_r;
    ram_waddr = b_waddr_r;
    ram_wdata = mac_wdata;
    ram_re    = 1'b0;
    ram_raddr = tap_addr;
    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = row_base(clr_row_r) + cnt_r;
        ram_wdata = '0;
      end
      S_FRD: begin
        ram_re    = inside_r;
        ram_raddr = fetch_addr;
      end
      S_STO: begin
        ram_re    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mede_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mede_mac #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_mac (
    .clk     (clk),
    .a_valid (state_r == S_STO),
    .err     (err_r),
    .weight  (tap_w),
    .rdata   (ram_rdata),
    .wdata   (mac_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= '0;
      width_r  <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER: filter_r <= cfg_wdata[2:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CHANNEL_BITS-1:0] ent;
    logic signed [OW-1:0]           ext;
    if (!rst_n) begin
      state_r     <= S_INIT;
      top_r       <= '0;
      cnt_r       <= '0;
      b_we_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_we_r    <= (state_r == S_STO) && tap_valid;
      b_waddr_r <= tap_addr;
      if (out_valid_r && !out_stall && (state_r != S_FOUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (cnt_r == AW'(DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            col_r    <= in_column;
            inside_r <= in_line;
            err_r    <= {in_err_alpha, in_err_blue, in_err_green, in_err_red};
            tap_r    <= '0;
            cnt_r    <= '0;
            if (in_mode == MODE_FETCH) begin
              if (in_column == 10'd0) begin
                // new line: old top row becomes the newest, cleared
                top_r     <= (32'(top_r) == ERROR_ROWS - 1) ? 2'd0 : top_r + 2'd1;
                clr_row_r <= top_r;
                state_r   <= S_CLR;
              end else begin
                state_r <= S_FRD;
              end
            end else if (in_line) begin
              state_r <= S_STO;
            end
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(ROW_LEN - 1)) begin
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          state_r <= S_FOUT;
        end
        S_FOUT: begin
          if (!out_valid_r || !out_stall) begin
            for (int c = 0; c < 4; c++) begin
              ent = ram_rdata[c*CHANNEL_BITS +: CHANNEL_BITS];
              ext = OW'(ent);
              out_r[c] <= inside_r ? ext[15:0] : '0;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_STO: begin
          tap_r <= tap_r + 4'd1;
          if (tap_r == 4'(NUM_TAPS - 1)) begin
            state_r <= S_DRN;
          end
        end
        S_DRN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_offset_red   = out_r[0];
  assign out_offset_green = out_r[1];
  assign out_offset_blue  = out_r[2];
  assign out_offset_alpha = out_r[3];

endmodule
